/* sv/xed_pkg.sv */
// Shared types, entity tables and helpers for the XML entity decoder.
`timescale 1ns / 1ps

package xed_pkg;

  localparam int EntCount = 5;

  // Entity order: lt, gt, amp, quot, apos
  localparam logic [2:0] ENT_LEN  [EntCount] = '{3'd3, 3'd3, 3'd4, 3'd5, 3'd5};
  localparam logic [7:0] ENT_CHAR [EntCount] = '{8'h3C, 8'h3E, 8'h26, 8'h22, 8'h27};

  localparam logic [7:0] CHAR_AMP  = 8'h26;
  localparam logic [4:0] ALL_CANDS = 5'b11111;

  typedef struct packed {
    logic [7:0] ch;
    logic       valid;
    logic       bad;
    logic       last;
  } xed_res_t;

  // Body byte of entity e after the '&' at offset idx (the closing ';' included).
  function automatic logic [7:0] ent_byte(input int e, input logic [2:0] idx);
    logic [39:0] body;
    logic [7:0]  b;
    case (e)
      0:       body = {8'h00, 8'h00, ";", "t", "l"};
      1:       body = {8'h00, 8'h00, ";", "t", "g"};
      2:       body = {8'h00, ";", "p", "m", "a"};
      3:       body = {";", "t", "o", "u", "q"};
      default: body = {";", "s", "o", "p", "a"};
    endcase
    case (idx)
      3'd0:    b = body[7:0];
      3'd1:    b = body[15:8];
      3'd2:    b = body[23:16];
      3'd3:    b = body[31:24];
      3'd4:    b = body[39:32];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* sv/xed_step.sv */
// Entity match state and the per-item decode step.
`timescale 1ns / 1ps

module xed_step import xed_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       adv,
  input  logic [7:0] in_char,
  input  logic       in_last,
  output logic       has_result,
  output xed_res_t   result
);

  logic [2:0] pos, pos_next;
  logic [4:0] mask, mask_next;
  logic       skip, skip_next;

  logic [2:0] idx;
  logic [4:0] cont_mask;
  logic       hit_done;
  logic [7:0] done_char;

  xed_res_t err_res;

  assign idx     = pos - 3'd1;
  assign err_res = '{ch: 8'h00, valid: 1'b0, bad: 1'b1, last: 1'b1};

  // Compare the byte against every live candidate at this offset.
  always_comb begin
    hit_done  = 1'b0;
    done_char = 8'h00;
    cont_mask = '0;
    for (int i = 0; i < EntCount; i++) begin
      if (mask[i] && (idx < ENT_LEN[i]) && (ent_byte(i, idx) == in_char)) begin
        if (({1'b0, idx} + 4'd1) == {1'b0, ENT_LEN[i]}) begin
          if (!hit_done) done_char = ENT_CHAR[i];
          hit_done = 1'b1;
        end else begin
          cont_mask[i] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    pos_next   = pos;
    mask_next  = mask;
    skip_next  = skip;
    has_result = 1'b0;
    result     = '{ch: in_char, valid: 1'b1, bad: 1'b0, last: in_last};
    if (skip) begin
      if (in_last) begin
        has_result = 1'b1;
        result     = err_res;
        skip_next  = 1'b0;
      end
    end else if (pos == 3'd0) begin
      if (in_char == CHAR_AMP) begin
        if (in_last) begin
          has_result = 1'b1;
          result     = err_res;
        end else begin
          pos_next  = 3'd1;
          mask_next = ALL_CANDS;
        end
      end else begin
        has_result = 1'b1;
      end
    end else if (hit_done) begin
      has_result = 1'b1;
      result.ch  = done_char;
      pos_next   = 3'd0;
      mask_next  = '0;
    end else if (cont_mask == '0 || in_last) begin
      // Mismatch or cut-off entity: error now on a last byte, else skip.
      pos_next  = 3'd0;
      mask_next = '0;
      if (in_last) begin
        has_result = 1'b1;
        result     = err_res;
      end else begin
        skip_next = 1'b1;
      end
    end else begin
      mask_next = cont_mask;
      pos_next  = pos + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      mask <= '0;
      skip <= 1'b0;
    end else if (adv) begin
      pos  <= pos_next;
      mask <= mask_next;
      skip <= skip_next;
    end
  end

endmodule

/* sv/xml_entity_decoder_core.sv */
// Top level of the XML predefined-entity decoder: input and result registers.
`timescale 1ns / 1ps
//
// Decodes the five predefined XML entities (&lt; &gt; &amp; &quot; &apos;)
// in a byte stream. The slave side (s_*) takes one text byte per item with
// s_tlast on the final byte of a message. The master side (m_*) gives zero
// or one result per input item: a decoded byte, or on an unknown or cut-off
// entity a single error item (bad_entity set, tlast set) at the end of the
// message. Bytes already delivered for a flagged message are not withdrawn;
// the receiver must drop the whole message.
//
// An accepted item sits in the input register, is decoded there by the
// match step and its result is presented from the result register.
// Throughput: one item per cycle while the receiver takes results, set by
// the match of the byte against the live entity candidates.
// When the receiver stalls, the result register holds and the input
// register fills; s_tready then drops until the result is taken.
// Reset clears the match state and empties both registers.
//
module xml_entity_decoder_core import xed_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_char
  input  logic        s_tlast,   // in_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_char, [8] char_valid, [9] bad_entity, zeros above
  output logic        m_tlast    // out_last
);

  // Input register
  logic       in_valid;
  logic [7:0] in_char;
  logic       in_last;

  // Result register
  logic       res_valid;
  xed_res_t   res;

  logic       adv;
  logic       has_result;
  xed_res_t   step_res;

  // Advance the held item when the result register is free or being taken.
  assign adv      = in_valid && (!res_valid || m_tready);
  assign s_tready = !in_valid || adv;

  xed_step u_step (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_char    (in_char),
    .in_last    (in_last),
    .has_result (has_result),
    .result     (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_char <= s_tdata;
      in_last <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= has_result;
    end else if (m_tready) begin
      res_valid <= 1'b0;
    end
  end

  // Load the result; the error item already carries a zero character.
  always_ff @(posedge clk) begin
    if (adv && has_result) begin
      res <= step_res;
    end
  end

  assign m_tvalid = res_valid;
  assign m_tdata  = {6'b000000, res.bad, res.valid, res.ch};
  assign m_tlast  = res.last;

endmodule

/* verif/tb_xml_entity_decoder_core.sv */
// Self-checking stream testbench for the XML entity decoder core.
`timescale 1ns / 1ps

module tb_xml_entity_decoder_core;
  import xed_pkg::*;

  // One text byte waiting to be offered. "drain" makes the sender hold this
  // item back until every result predicted so far has been taken.
  typedef struct {
    logic [7:0] ch;
    logic       fin;
    bit         drain;
  } text_item_t;

  // One decoded result as the block should present it.
  typedef struct {
    logic [7:0] ch;
    logic       valid;
    logic       bad;
    logic       fin;
  } decoded_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;    // [7:0] in_char
  logic        s_tlast = 1'b0;     // in_last
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;            // [7:0] out_char, [8] char_valid, [9] bad_entity, zeros above
  logic        m_tlast;            // out_last

  xml_entity_decoder_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #2 clk = ~clk;

  // Entity bodies after the '&', closing ';' included, and the character each
  // one decodes to. Order: lt, gt, amp, quot, apos.
  string      entity_body  [5] = '{"lt;", "gt;", "amp;", "quot;", "apos;"};
  logic [7:0] entity_glyph [5] = '{"<", ">", "&", "\"", "'"};

  text_item_t text_q[$];        // bytes still to be offered
  decoded_t   results_due[$];   // predicted results, oldest first

  // Decoder state as predicted from the accepted bytes.
  logic [2:0] ent_pos   = '0;
  logic [4:0] cand_mask = '0;
  logic       skipping  = 1'b0;

  int  n_errors     = 0;
  int  bytes_sent   = 0;
  int  results_seen = 0;
  int  n_messages   = 0;
  int  n_entities   = 0;
  int  n_flagged    = 0;
  logic calm    = 1'b0;         // no random idling on either side while set
  logic rx_hold = 1'b0;         // receiver holds off while set

  task automatic report_mismatch(input string field, input int got, input int wanted);
    n_errors++;
    if (n_errors <= 30)
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field, got,
               wanted);
  endtask

  task automatic expect_result(input logic [7:0] ch, input logic valid, input logic bad,
                               input logic fin);
    decoded_t r;
    r.ch = ch;
    r.valid = valid;
    r.bad = bad;
    r.fin = fin;
    results_due.push_back(r);
  endtask

  // Error result closes the message and returns the decoder to its idle state.
  task automatic flag_bad_message();
    expect_result(8'h00, 1'b0, 1'b1, 1'b1);
    n_flagged++;
    ent_pos = '0;
    cand_mask = '0;
    skipping = 1'b0;
  endtask

  // Advance the predicted decoder by one accepted byte.
  task automatic decode_byte(input logic [7:0] c, input logic fin);
    int         idx;
    logic [4:0] keep;
    bit         done;
    keep = '0;
    done = 0;
    if (fin)
      n_messages++;
    if (skipping) begin
      // Drop everything up to the last byte of a broken message.
      if (fin)
        flag_bad_message();
    end else if (ent_pos == 0) begin
      if (c == "&") begin
        if (fin) begin
          flag_bad_message();
        end else begin
          ent_pos = 3'd1;
          cand_mask = '1;
        end
      end else begin
        expect_result(c, 1'b1, 1'b0, fin);
      end
    end else begin
      // Match against every entity still in play at this offset.
      idx = ent_pos - 1;
      for (int e = 0; e < 5; e++) begin
        if (!done && cand_mask[e] && idx < entity_body[e].len() &&
            entity_body[e][idx] == c) begin
          if (idx + 1 == entity_body[e].len()) begin
            expect_result(entity_glyph[e], 1'b1, 1'b0, fin);
            n_entities++;
            ent_pos = '0;
            cand_mask = '0;
            done = 1;
          end else begin
            keep[e] = 1'b1;
          end
        end
      end
      if (!done) begin
        if (fin) begin
          // Cut-off or mismatch on the last byte: flag at once.
          flag_bad_message();
        end else if (keep == '0) begin
          ent_pos = '0;
          cand_mask = '0;
          skipping = 1'b1;
        end else begin
          cand_mask = keep;
          ent_pos = ent_pos + 3'd1;
        end
      end
    end
  endtask

  task automatic push_byte(input logic [7:0] ch, input logic fin, input bit drain);
    text_item_t it;
    it.ch = ch;
    it.fin = fin;
    it.drain = drain;
    text_q.push_back(it);
  endtask

  // Queue a whole message; its final byte carries the last flag.
  task automatic queue_text(input string s, input bit drain);
    for (int k = 0; k < s.len(); k++)
      push_byte(s[k], k == s.len() - 1, drain && k == 0);
  endtask

  // Sender: hold an offered byte until it is taken, then either offer the
  // next one or idle.
  always @(posedge clk) begin : drive_text
    text_item_t nxt;
    bit         offering;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'h00;
      s_tlast  <= 1'b0;
    end else begin
      offering = s_tvalid;
      if (s_tvalid && s_tready) begin
        decode_byte(s_tdata, s_tlast);
        bytes_sent++;
        offering = 0;
      end
      calm <= (bytes_sent >= 260 && bytes_sent < 390);
      if (!offering) begin
        if (text_q.size() != 0 && !(text_q[0].drain && results_due.size() != 0) &&
            (calm || $urandom_range(99) >= 10)) begin
          nxt = text_q.pop_front();
          s_tdata  <= nxt.ch;
          s_tlast  <= nxt.fin;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each taken result against the oldest prediction, then
  // pick tready for the next edge.
  always @(posedge clk) begin : watch_results
    decoded_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (results_due.size() == 0) begin
        report_mismatch("unexpected result", m_tdata, 0);
      end else begin
        want = results_due.pop_front();
        if (m_tdata[7:0] !== want.ch)
          report_mismatch("out_char", m_tdata[7:0], want.ch);
        if (m_tdata[8] !== want.valid)
          report_mismatch("char_valid", m_tdata[8], want.valid);
        if (m_tdata[9] !== want.bad)
          report_mismatch("bad_entity", m_tdata[9], want.bad);
        if (m_tdata[15:10] !== 6'd0)
          report_mismatch("tdata padding", m_tdata[15:10], 0);
        if (m_tlast !== want.fin)
          report_mismatch("out_last", m_tlast, want.fin);
      end
    end
    m_tready <= !rst && !rx_hold && (calm || $urandom_range(99) >= 10);
  end

  // Back-pressure: stall the receiver long enough for the block to fill up
  // and drop s_tready while the sender keeps offering.
  initial begin : long_stall
    wait (bytes_sent >= 120);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (60) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin : watchdog
    #200000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] msg[$];
    int         pick;
    int         e;
    int         cut;
    int         guard;
    int         n_total;
    bit         drain;
    bit         mid_drain_done;
    mid_drain_done = 0;

    // Directed: byte extremes, each special case, one entity ending a message.
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b1, 1'b0);
    queue_text("&", 0);          // ampersand on the last byte
    queue_text("&am", 0);        // entity cut off by the end of the message
    queue_text("&x", 0);         // mismatch on the last byte
    queue_text("&lxyz", 0);      // mismatch, then skip to the last byte
    queue_text("&apos;", 0);     // entity completed on the last byte
    queue_text("&lt;A", 0);      // entity completed mid-message

    // Random: mostly well-formed entities among plain bytes, some broken
    // entities and a few messages that stop inside one.
    while (text_q.size() < 523) begin
      msg.delete();
      repeat ($urandom_range(1, 8)) begin
        pick = $urandom_range(99);
        e = $urandom_range(4);
        if (pick < 45) begin
          msg.push_back(8'($urandom_range(255)));
        end else if (pick < 85) begin
          msg.push_back("&");
          for (int k = 0; k < entity_body[e].len(); k++)
            msg.push_back(entity_body[e][k]);
        end else begin
          cut = $urandom_range(entity_body[e].len() - 1);
          msg.push_back("&");
          for (int k = 0; k < cut; k++)
            msg.push_back(entity_body[e][k]);
          msg.push_back(8'($urandom_range(255)));
        end
      end
      if ($urandom_range(9) == 0) begin
        e = $urandom_range(4);
        cut = $urandom_range(entity_body[e].len() - 1);
        msg.push_back("&");
        for (int k = 0; k < cut; k++)
          msg.push_back(entity_body[e][k]);
      end
      // Pause the sender once after the directed part and once mid-run.
      drain = (text_q.size() == 24) || (!mid_drain_done && text_q.size() >= 330);
      if (text_q.size() >= 330)
        mid_drain_done = 1;
      foreach (msg[k])
        push_byte(msg[k], k == msg.size() - 1, drain && k == 0);
    end
    n_total = text_q.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Wait for every byte to be taken, then for the results to drain.
    while (bytes_sent < n_total)
      @(posedge clk);
    guard = 0;
    while (results_due.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (results_due.size() != 0)
      report_mismatch("results never delivered", 0, results_due.size());

    $display("Sent %0d bytes in %0d messages; checked %0d results", bytes_sent, n_messages,
             results_seen);
    $display("Covered %0d decoded entities and %0d flagged messages", n_entities, n_flagged);
    if (n_errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

/* filelist.f */
sv/xed_pkg.sv
sv/xed_step.sv
sv/xml_entity_decoder_core.sv
verif/tb_xml_entity_decoder_core.sv
